### sv/cclx_pkg.sv
package cclx_pkg;

  localparam int unsigned CharW = 21;
  localparam int unsigned CtxW  = 8;

  typedef logic [CharW-1:0] char_t;
  typedef logic [CtxW-1:0]  ctx_t;

  // context bits
  localparam ctx_t CTX_BLOCK  = 8'h01;
  localparam ctx_t CTX_LINE   = 8'h02;
  localparam ctx_t CTX_DQ     = 8'h04;
  localparam ctx_t CTX_SQ     = 8'h08;
  localparam ctx_t CTX_ESC    = 8'h10;
  localparam ctx_t CTX_WORD   = 8'h20;
  localparam ctx_t CTX_NL     = 8'h40;
  localparam ctx_t CTX_INDENT = 8'h80;
  localparam ctx_t CTX_CORE   = 8'h1F;
  localparam ctx_t CTX_NONE   = 8'h00;

  // colour classes
  localparam logic [1:0] COLOR_PLAIN = 2'd0;
  localparam logic [1:0] COLOR_STR   = 2'd1;
  localparam logic [1:0] COLOR_BLOCK = 2'd2;
  localparam logic [1:0] COLOR_LINE  = 2'd3;

  localparam logic [1:0] SPAN_NONE = 2'd0;
  localparam logic [1:0] SPAN_ONE  = 2'd1;
  localparam logic [1:0] SPAN_TWO  = 2'd2;

  // characters
  localparam char_t CH_NUL    = 21'h00;
  localparam char_t CH_TAB    = 21'h09;
  localparam char_t CH_LF     = 21'h0A;
  localparam char_t CH_SPACE  = 21'h20;
  localparam char_t CH_DQUOTE = 21'h22;
  localparam char_t CH_SQUOTE = 21'h27;
  localparam char_t CH_STAR   = 21'h2A;
  localparam char_t CH_SLASH  = 21'h2F;
  localparam char_t CH_ZERO   = 21'h30;
  localparam char_t CH_NINE   = 21'h39;
  localparam char_t CH_UP_A   = 21'h41;
  localparam char_t CH_UP_Z   = 21'h5A;
  localparam char_t CH_BSLASH = 21'h5C;
  localparam char_t CH_UNDER  = 21'h5F;
  localparam char_t CH_LO_A   = 21'h61;
  localparam char_t CH_LO_Z   = 21'h7A;

  typedef struct packed {
    logic [1:0] color_class;
    logic [1:0] span_length;
    logic       keyword_probe;
    ctx_t       context_out;
  } lex_res_t;

endpackage

### sv/cclx_if.sv
interface cclx_in_if;
  logic            valid;
  logic            ready;
  cclx_pkg::char_t cur_char;
  cclx_pkg::char_t next_char;

  modport source (output valid, output cur_char, output next_char, input ready);
  modport sink   (input valid, input cur_char, input next_char, output ready);
endinterface

interface cclx_out_if;
  logic           valid;
  logic           ready;
  logic [1:0]     color_class;
  logic [1:0]     span_length;
  logic           keyword_probe;
  cclx_pkg::ctx_t context_out;

  modport source (output valid, output color_class, output span_length,
                  output keyword_probe, output context_out, input ready);
  modport sink   (input valid, input color_class, input span_length,
                  input keyword_probe, input context_out, output ready);
endinterface

### sv/cclx_step.sv
module cclx_step (
  input  cclx_pkg::ctx_t   ctx_i,
  input  cclx_pkg::char_t  cur_char_i,
  input  cclx_pkg::char_t  next_char_i,
  output cclx_pkg::lex_res_t res_o
);
  import cclx_pkg::*;

  ctx_t       core;
  ctx_t       after;
  ctx_t       both;
  logic [1:0] len;
  logic       is_word;
  logic       c_nl;

  assign core = ctx_i & CTX_CORE;
  assign c_nl = (cur_char_i == CH_LF);
  assign is_word = ((cur_char_i >= CH_LO_A) && (cur_char_i <= CH_LO_Z)) ||
                   ((cur_char_i >= CH_UP_A) && (cur_char_i <= CH_UP_Z)) ||
                   ((cur_char_i >= CH_ZERO) && (cur_char_i <= CH_NINE)) ||
                   (cur_char_i == CH_UNDER);

  always_comb begin
    ctx_t nxt;
    nxt = ctx_i;
    len = SPAN_ONE;
    if ((core & CTX_ESC) != CTX_NONE) begin
      nxt = ctx_i & ~CTX_ESC;
    end else if (cur_char_i == CH_SLASH && next_char_i == CH_STAR && core == CTX_NONE) begin
      len = SPAN_TWO;
      nxt = CTX_BLOCK;
    end else if (cur_char_i == CH_STAR && next_char_i == CH_SLASH && core == CTX_BLOCK) begin
      len = SPAN_TWO;
      nxt = CTX_NONE;
    end else if (cur_char_i == CH_SLASH && next_char_i == CH_SLASH && core == CTX_NONE) begin
      len = SPAN_TWO;
      nxt = CTX_LINE;
    end else if (c_nl && core == CTX_LINE) begin
      nxt = CTX_NONE;
    end else if (cur_char_i == CH_BSLASH && (core == CTX_DQ || core == CTX_SQ)) begin
      nxt = ctx_i | CTX_ESC;
    end else if (cur_char_i == CH_DQUOTE && core == CTX_NONE) begin
      nxt = CTX_DQ;
    end else if ((cur_char_i == CH_DQUOTE || c_nl) && core == CTX_DQ) begin
      nxt = CTX_NONE;
    end else if (cur_char_i == CH_SQUOTE && core == CTX_NONE) begin
      nxt = CTX_SQ;
    end else if ((cur_char_i == CH_SQUOTE || c_nl) && core == CTX_SQ) begin
      nxt = CTX_NONE;
    end else if (cur_char_i != CH_TAB && cur_char_i != CH_SPACE && core == CTX_NONE) begin
      nxt = CTX_NONE;
    end else if (ctx_i == CTX_NL) begin
      nxt = CTX_INDENT;
    end else if (cur_char_i == CH_NUL || c_nl) begin
      nxt = CTX_NL;
    end
    if (is_word) begin
      nxt = nxt | CTX_WORD;
    end
    after = nxt;
  end

  assign both = ctx_i | after;

  always_comb begin
    res_o.context_out   = after;
    res_o.keyword_probe = 1'b0;
    res_o.span_length   = len;
    res_o.color_class   = COLOR_PLAIN;
    if ((both & (CTX_DQ | CTX_SQ)) != CTX_NONE) begin
      res_o.color_class = COLOR_STR;
    end else if ((both & CTX_BLOCK) != CTX_NONE) begin
      res_o.color_class = COLOR_BLOCK;
    end else if ((both & CTX_LINE) != CTX_NONE) begin
      res_o.color_class = COLOR_LINE;
    end else if ((after & CTX_INDENT) != CTX_NONE) begin
      res_o.span_length = SPAN_NONE;
    end else begin
      res_o.span_length   = SPAN_NONE;
      res_o.keyword_probe = ((ctx_i & CTX_WORD) == CTX_NONE);
    end
  end

endmodule

### sv/c_comment_string_lexer.sv
// c comment and string lexer for syntax colouring
//
// in_i carries one code point per beat (cur_char) with the following code
// point as lookahead (next_char). out_o returns one beat per input beat:
// colour class, span length, keyword probe and the new lexical context.
//
// path: a beat taken is registered in the input register, runs through the
// lexer step and is registered in the result register that drives out_o.
// throughput: one beat per cycle while out_o is not stalled; the limit is
// the eight-bit context register update, which feeds the next beat's step.
//
// reset clears the context to plain code and empties both registers.
// when the receiver stalls, the result beat is held and one more input
// beat waits in the input register; in_i.ready falls only once both are
// full, and rises again in the cycle the result beat is taken.
module c_comment_string_lexer (
  input  logic              clk_i,
  input  logic              rst_ni,
  cclx_in_if.sink           in_i,
  cclx_out_if.source        out_o
);
  import cclx_pkg::*;

  logic     in_valid_q;
  char_t    cur_q;
  char_t    next_q;
  ctx_t     ctx_q;
  logic     out_valid_q;
  lex_res_t res_q;
  lex_res_t res_d;
  logic     out_free;
  logic     step_fire;
  logic     in_fire;

  assign out_free  = !out_valid_q || out_o.ready;
  assign step_fire = in_valid_q && out_free;
  assign in_i.ready = !in_valid_q || out_free;
  assign in_fire   = in_i.valid && in_i.ready;

  cclx_step u_step (
    .ctx_i       (ctx_q),
    .cur_char_i  (cur_q),
    .next_char_i (next_q),
    .res_o       (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      ctx_q       <= CTX_NONE;
    end else begin
      if (in_fire) begin
        in_valid_q <= 1'b1;
      end else if (step_fire) begin
        in_valid_q <= 1'b0;
      end
      if (step_fire) begin
        out_valid_q <= 1'b1;
        ctx_q       <= res_d.context_out;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cur_q  <= in_i.cur_char;
      next_q <= in_i.next_char;
    end
    if (step_fire) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.color_class   = res_q.color_class;
  assign out_o.span_length   = res_q.span_length;
  assign out_o.keyword_probe = res_q.keyword_probe;
  assign out_o.context_out   = res_q.context_out;

`ifndef SYNTH
  a_ctx_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_fire |=> $stable(ctx_q))
    else $error("context changed without a step");

  a_ctx_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_fire |=> (out_valid_q && (res_q.context_out == ctx_q)))
    else $error("result context differs from stored context");

  a_probe_plain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.keyword_probe) |->
      (res_q.color_class == COLOR_PLAIN && res_q.span_length == SPAN_NONE))
    else $error("keyword probe outside plain text");

  a_span_colour: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.span_length != SPAN_NONE) |->
      (res_q.color_class != COLOR_PLAIN))
    else $error("span on plain text");

  a_no_loss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !out_free) |=> in_valid_q)
    else $error("pending input beat dropped");
`endif

endmodule
